### src/separable_gaussian_blur_core_defines.svh
// assertion macros shared by the blur core modules
`ifndef SEPARABLE_GAUSSIAN_BLUR_CORE_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_CORE_DEFINES_SVH

// same-cycle implication, clocked by i_clk, off during reset
`define SGB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by i_clk, off during reset
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sgb_pkg.sv
// types, constants and helper functions of the separable blur core
package sgb_pkg;

    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int RAD_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int ROW_SLOTS  = 16;
    localparam int TAP_W      = 16;
    localparam int NUM_TAPS   = 8;
    localparam int PIX_W      = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_HIGH    = 3'd4;

    localparam logic ACT_PIXEL = 1'b0;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_beat;

    typedef struct packed {
        logic [COL_W-1:0] w;
        logic [ROW_W-1:0] h;
        logic [RAD_W-1:0] r;
    } t_geom;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             last;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [COL_W-1:0]  col;
        logic [PIX_W-1:0]  pixel;
    } t_mem_wr;

    typedef struct packed {
        logic             busy;
        logic [ROW_W-1:0] row;
    } t_guard;

    typedef struct packed {
        logic [RAD_W-1:0] vtap;
        logic [RAD_W-1:0] htap;
        logic             vfirst;
        logic             vlast;
        logic             hfirst;
        logic             hlast;
    } t_tap_tag;

    function automatic logic [TAP_W-1:0] tap_of(input logic [2*CFG_DATA_W-1:0] taps,
                                                 input logic [RAD_W-1:0] k);
        return taps[k*TAP_W +: TAP_W];
    endfunction

endpackage

### src/sgb_queue.sv
// two-entry job queue between the front and back parts
module sgb_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  sgb_pkg::t_job i_push_job,
    input  logic        i_pop,
    output sgb_pkg::t_job o_head,
    output logic        o_empty,
    output logic        o_full
);
    import sgb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_ent [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_ent[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

### src/sgb_front.sv
// front part: takes beats, stores pixels, decides which output is due
`include "separable_gaussian_blur_core_defines.svh"
module sgb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgb_pkg::t_geom    i_geom,
    input  logic              i_restart,
    input  logic              i_in_valid,
    input  sgb_pkg::t_in_beat i_in_data,
    output logic              o_in_stall,
    input  logic              i_q_full,
    input  sgb_pkg::t_guard   i_guard,
    output logic              o_push,
    output sgb_pkg::t_job     o_push_job,
    output sgb_pkg::t_mem_wr  o_wr
);
    import sgb_pkg::*;

    logic [COL_W-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row, n_in_row, n_out_row;
    logic             r_flush_hold, n_flush_hold;

    logic [COL_W-1:0] c_in_col, c_out_col, p_in_col, nx;
    logic [ROW_W-1:0] c_in_row, c_out_row, p_in_row, ny;
    logic             bad, accept, pixel, ready, last;
    logic [COL_W:0]   col_inc, col_reach;
    logic [ROW_W:0]   row_reach;
    logic signed [ROW_W+1:0] lead;

    always_comb begin
        // rows ahead of the oldest job still reading the line store
        lead = signed'({2'b00, r_in_row}) - signed'({2'b00, i_guard.row});
        // jobs of the previous frame block the next frame entirely
        o_in_stall = i_q_full ||
            (i_guard.busy && (r_flush_hold || lead < 0 ||
                lead > signed'((ROW_W+2)'(ROW_SLOTS - 1) - (ROW_W+2)'(i_geom.r))));
        accept = i_in_valid && !o_in_stall;

        bad = (r_in_col >= i_geom.w) || (r_in_row > i_geom.h) ||
              (r_out_col >= i_geom.w) || (r_out_row >= i_geom.h);
        c_in_col  = bad ? '0 : r_in_col;
        c_in_row  = bad ? '0 : r_in_row;
        c_out_col = bad ? '0 : r_out_col;
        c_out_row = bad ? '0 : r_out_row;

        pixel   = (i_in_data.action == ACT_PIXEL) && (c_in_row < i_geom.h);
        col_inc = {1'b0, c_in_col} + 1'b1;
        p_in_col = c_in_col;
        p_in_row = c_in_row;
        if (pixel) begin
            if (col_inc >= {1'b0, i_geom.w}) begin
                p_in_col = '0;
                p_in_row = c_in_row + 1'b1;
            end else begin
                p_in_col = col_inc[COL_W-1:0];
            end
        end

        col_reach = {1'b0, c_out_col} + (COL_W+1)'(i_geom.r);
        nx = (col_reach > (COL_W+1)'(i_geom.w - 1'b1)) ? i_geom.w - 1'b1
                                                       : col_reach[COL_W-1:0];
        row_reach = {1'b0, c_out_row} + (ROW_W+1)'(i_geom.r);
        ny = (row_reach > (ROW_W+1)'(i_geom.h - 1'b1)) ? i_geom.h - 1'b1
                                                       : row_reach[ROW_W-1:0];
        ready = (p_in_row > ny) || ((p_in_row == ny) && (p_in_col > nx));
        last  = (c_out_col == i_geom.w - 1'b1) && (c_out_row == i_geom.h - 1'b1);

        o_push     = accept && ready;
        o_push_job = '{x: c_out_col, y: c_out_row, last: last};

        o_wr.en    = accept && pixel;
        o_wr.slot  = c_in_row[SLOT_W-1:0];
        o_wr.col   = c_in_col;
        o_wr.pixel = {i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in};

        n_flush_hold = r_flush_hold && i_guard.busy;
        if (o_push && last) begin
            n_flush_hold = 1'b1;
        end

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept) begin
            n_in_col  = p_in_col;
            n_in_row  = p_in_row;
            n_out_col = c_out_col;
            n_out_row = c_out_row;
            if (o_push) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (c_out_col == i_geom.w - 1'b1) begin
                    n_out_col = '0;
                    n_out_row = c_out_row + 1'b1;
                end else begin
                    n_out_col = c_out_col + 1'b1;
                end
            end
        end
        if (i_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_flush_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_flush_hold <= 1'b0;
        end else begin
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_flush_hold <= n_flush_hold;
        end
    end

    `SGB_ASSERT_NEXT(a_last_restarts, o_push && last, r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0, "frame end did not restart positions")
    `SGB_ASSERT_SAME(a_row_in_frame, !i_restart, r_in_row <= i_geom.h, "input row beyond frame")

endmodule

### src/sgb_back.sv
// back part: line store and shared tap pipeline producing one output pixel
`include "separable_gaussian_blur_core_defines.svh"
module sgb_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sgb_pkg::t_geom         i_geom,
    input  logic [127:0]           i_taps,
    input  sgb_pkg::t_mem_wr       i_wr,
    input  logic                   i_q_empty,
    input  sgb_pkg::t_job          i_q_head,
    output logic                   o_pop,
    output sgb_pkg::t_guard        o_job_state,
    output logic                   o_out_valid,
    output sgb_pkg::t_out_beat     o_out_data,
    input  logic                   i_out_stall
);
    import sgb_pkg::*;

    localparam int DEPTH = ROW_SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int VA_W  = 28;
    localparam int HA_W  = 36;
    localparam int SW    = ROW_W + 2;

    logic [PIX_W-1:0] r_mem [DEPTH];

    logic             r_busy, r_issuing, r_out_valid, r_fin;
    t_job             r_job;
    logic signed [RAD_W:0] r_vi, r_hj;
    t_out_beat        r_out;

    logic [PIX_W-1:0] r_rd;
    logic             r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    t_tap_tag         r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    logic [23:0]      r_p    [3];
    logic [VA_W-1:0]  r_vacc [3];
    logic [15:0]      r_v    [3];
    logic [31:0]      r_hp   [3];
    logic [HA_W-1:0]  r_hacc [3];

    logic [AW-1:0]    w_rd_addr, w_wr_addr;
    logic signed [SW-1:0] row_s, col_s;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
    logic signed [RAD_W:0] rs;
    t_tap_tag         tag0;
    logic             start;
    logic [VA_W-1:0]  vround [3];
    logic [HA_W-1:0]  hround [3];
    logic [7:0]       ch_out [3];

    function automatic logic [RAD_W-1:0] mag(input logic signed [RAD_W:0] v);
        return v[RAD_W] ? RAD_W'(-v) : RAD_W'(v);
    endfunction

    assign start = !r_busy && !i_q_empty && !r_out_valid;
    assign o_pop = start;
    assign o_job_state = '{busy: r_busy, row: r_job.y};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        rs    = signed'({1'b0, i_geom.r});
        row_s = signed'(SW'(r_job.y)) + SW'(r_vi);
        col_s = signed'(SW'(r_job.x)) + SW'(r_hj);
        if (row_s < 0) begin
            rd_row = '0;
        end else if (row_s >= signed'(SW'(i_geom.h))) begin
            rd_row = i_geom.h - 1'b1;
        end else begin
            rd_row = row_s[ROW_W-1:0];
        end
        if (col_s < 0) begin
            rd_col = '0;
        end else if (col_s >= signed'(SW'(i_geom.w))) begin
            rd_col = i_geom.w - 1'b1;
        end else begin
            rd_col = col_s[COL_W-1:0];
        end
        w_rd_addr = AW'(int'(rd_row[SLOT_W-1:0]) * MAX_WIDTH + int'(rd_col));
        w_wr_addr = AW'(int'(i_wr.slot) * MAX_WIDTH + int'(i_wr.col));
        tag0.vtap   = mag(r_vi);
        tag0.htap   = mag(r_hj);
        tag0.vfirst = (r_vi == -rs);
        tag0.vlast  = (r_vi == rs);
        tag0.hfirst = (r_hj == -rs);
        tag0.hlast  = (r_hj == rs) && (r_vi == rs);
        for (int c = 0; c < 3; c++) begin
            vround[c] = r_vacc[c] + VA_W'(128);
            hround[c] = r_hacc[c] + HA_W'(1 << 23);
            ch_out[c] = (hround[c][HA_W-1:24] > 12'd255) ? 8'hFF : hround[c][31:24];
        end
    end

    // line store: front writes, tap pipeline reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_wr_addr] <= i_wr.pixel;
        end
        if (r_issuing) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job <= i_q_head;
        end
        r_s1_tag <= tag0;
        r_s2_tag <= r_s1_tag;
        r_s3_tag <= r_s2_tag;
        r_s4_tag <= r_s3_tag;
        r_s5_tag <= r_s4_tag;
        for (int c = 0; c < 3; c++) begin
            r_p[c] <= tap_of(i_taps, r_s1_tag.vtap) * r_rd[8*c +: 8];
            if (r_s2_vld) begin
                r_vacc[c] <= (r_s2_tag.vfirst ? '0 : r_vacc[c]) + VA_W'(r_p[c]);
            end
            if (r_s3_vld && r_s3_tag.vlast) begin
                r_v[c] <= (vround[c][VA_W-1:8] > 20'hFFFF) ? 16'hFFFF : vround[c][23:8];
            end
            r_hp[c] <= tap_of(i_taps, r_s4_tag.htap) * r_v[c];
            if (r_s5_vld) begin
                r_hacc[c] <= (r_s5_tag.hfirst ? '0 : r_hacc[c]) + HA_W'(r_hp[c]);
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issuing   <= 1'b0;
            r_out_valid <= 1'b0;
            r_vi        <= '0;
            r_hj        <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_s5_vld    <= 1'b0;
        end else begin
            r_s1_vld <= r_issuing;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld && r_s3_tag.vlast;
            r_s5_vld <= r_s4_vld;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (start) begin
                r_busy    <= 1'b1;
                r_issuing <= 1'b1;
                r_vi      <= -rs;
                r_hj      <= -rs;
            end else if (r_issuing) begin
                if (r_vi == rs) begin
                    r_vi <= -rs;
                    if (r_hj == rs) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_hj <= r_hj + 1'b1;
                    end
                end else begin
                    r_vi <= r_vi + 1'b1;
                end
            end
            if (r_fin) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end
        end
    end

    // final rounding runs in the cycle after the last horizontal sum is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
        end else begin
            r_fin <= r_s5_vld && r_s5_tag.hlast;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_fin) begin
            r_out.red_out   <= ch_out[0];
            r_out.green_out <= ch_out[1];
            r_out.blue_out  <= ch_out[2];
            r_out.frame_end <= r_job.last;
        end
    end

    `SGB_ASSERT_SAME(a_no_rw_clash, r_issuing && i_wr.en, w_rd_addr != w_wr_addr, "line store read and write collide")
    `SGB_ASSERT_SAME(a_busy_slot_free, r_busy, !r_out_valid, "job running while result waits")
    `SGB_ASSERT_SAME(a_result_from_job, $rose(r_out_valid), $past(r_busy), "result without a job")

endmodule

### src/separable_gaussian_blur_core.sv
// top level of the separable blur core: config registers and part wiring
// usage:
//   input channel  i_in_valid / i_in_data / o_in_stall carries one beat per
//   pixel (action = pixel) or a drain tick (action = drain); a beat is taken
//   on a clock edge with valid high and stall low
//   output channel o_out_valid / o_out_data / i_out_stall returns blurred
//   pixels in raster order, frame_end marks the last pixel of a frame
//   config port i_cfg_we / i_cfg_index / i_cfg_data writes width, height,
//   radius and the two tap words; write only while the block is idle
//   the front stores pixels in a 16-row line store and queues output jobs;
//   the back computes each job through one shared tap pipeline
//   one output needs (2r+1)^2 line store reads, one per cycle on the single
//   read port, then passes through the tap pipeline; a new job starts only
//   after the previous result has left, so reads and pipeline set the throughput
//   input beats flow freely while the 2-entry job queue has room; the front
//   also holds off while a new row or a new frame would overwrite rows a job reads
//   a stalled receiver holds the finished pixel and stops new jobs from
//   starting; input keeps flowing until the queue fills
//   reset (synchronous, active low) clears positions and queue and loads the
//   default geometry 640x480, radius 3, taps zero; no clearing pass is needed
module separable_gaussian_blur_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  sgb_pkg::t_in_beat                   i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output sgb_pkg::t_out_beat                  o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sgb_pkg::*;

    // widest frame the line store and the column counters can hold
    localparam int WCAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

    logic [COL_W-1:0]      r_frame_width;
    logic [ROW_W-1:0]      r_frame_height;
    logic [RAD_W-1:0]      r_radius;
    logic [CFG_DATA_W-1:0] r_taps_low, r_taps_high;

    t_geom   geom;
    logic    restart;
    t_guard  guard, job_state;
    t_job    push_job, q_head;
    t_mem_wr wr;
    logic    push, pop, q_empty, q_full;

    // effective geometry: zero sizes act as one, oversize clamps
    always_comb begin
        if (r_frame_width == '0) begin
            geom.w = COL_W'(1);
        end else if ((COL_W+2)'(r_frame_width) > (COL_W+2)'(WCAP)) begin
            geom.w = COL_W'(WCAP);
        end else begin
            geom.w = r_frame_width;
        end
        geom.h = (r_frame_height == '0) ? ROW_W'(1) : r_frame_height;
        geom.r = (int'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius;
    end

    // any geometry write restarts the frame
    assign restart = i_cfg_we && (i_cfg_index == CFG_FRAME_WIDTH ||
                                  i_cfg_index == CFG_FRAME_HEIGHT ||
                                  i_cfg_index == CFG_RADIUS);

    // oldest job that still reads the line store
    always_comb begin
        guard.busy = job_state.busy || !q_empty;
        guard.row  = job_state.busy ? job_state.row : q_head.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= COL_W'(640);
            r_frame_height <= ROW_W'(480);
            r_radius       <= RAD_W'(3);
            r_taps_low     <= '0;
            r_taps_high    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[COL_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[ROW_W-1:0];
                CFG_RADIUS:       r_radius       <= i_cfg_data[RAD_W-1:0];
                CFG_TAPS_LOW:     r_taps_low     <= i_cfg_data;
                CFG_TAPS_HIGH:    r_taps_high    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sgb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_restart  (restart),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .i_guard    (guard),
        .o_push     (push),
        .o_push_job (push_job),
        .o_wr       (wr)
    );

    sgb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head     (q_head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    sgb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_taps      ({r_taps_high, r_taps_low}),
        .i_wr        (wr),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_job_state (job_state),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

### dv/testbench.sv
// self-checking testbench for the separable blur core with a built-in pixel predictor
`timescale 1ns / 1ps

module testbench;
    import sgb_pkg::*;

    localparam int LINE_COLS  = 1024;
    localparam int SETTLE_CYC = 300;    // a radius-7 output needs (2*7+1)^2 line store reads plus the pipeline
    localparam int HOLD_CYC   = 400;
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_GOAL  = 900;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        bit        has;
        t_out_beat want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    t_in_beat           i_in_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_beat          o_out_data;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    separable_gaussian_blur_core u_dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------- blur predictor state ----------------
    logic [23:0]  line_mem [0:ROW_SLOTS*LINE_COLS-1];
    int unsigned  width_reg, height_reg, radius_reg;
    logic [127:0] tap_words;
    int unsigned  in_x, in_y, out_x, out_y;

    t_out_beat    pixel_q [$];
    int           err_cnt, beats_in, beats_out, n_settings;

    // typed expectation that rides along with the beat being offered
    bit           cur_typed, cur_has;
    t_out_beat    cur_want;

    bit           hold_req, tx_calm, rx_calm;
    int           idle_cyc;

    function automatic int unsigned eff_w();
        int unsigned w = width_reg & 11'h7FF;
        if (w == 0) w = 1;
        if (w > LINE_COLS) w = LINE_COLS;
        return w;
    endfunction

    function automatic int unsigned eff_h();
        int unsigned h = height_reg & 12'hFFF;
        return (h == 0) ? 1 : h;
    endfunction

    function automatic longint unsigned tap_val(int k);
        return longint'(tap_words[k*16 +: 16]);
    endfunction

    function automatic int clamp_to(int v, int n);
        if (v < 0) return 0;
        if (v >= n) return n - 1;
        return v;
    endfunction

    function automatic longint unsigned chan(int col, int row, int ch);
        logic [23:0] p = line_mem[(row % ROW_SLOTS) * LINE_COLS + (col % LINE_COLS)];
        return longint'(p[ch*8 +: 8]);
    endfunction

    // vertical pass, unsigned Q8.8 result
    function automatic longint unsigned vpass(int col, int row, int ch, int h, int r);
        longint unsigned acc = tap_val(0) * chan(col, row, ch);
        for (int j = 1; j <= r; j++)
            acc += tap_val(j) * (chan(col, clamp_to(row - j, h), ch)
                                 + chan(col, clamp_to(row + j, h), ch));
        acc = (acc + 128) >> 8;
        return (acc > 65535) ? 65535 : acc;
    endfunction

    function automatic logic [7:0] blur_chan(int x, int y, int ch, int w, int h, int r);
        longint unsigned acc = tap_val(0) * vpass(x, y, ch, h, r);
        for (int j = 1; j <= r; j++)
            acc += tap_val(j) * (vpass(clamp_to(x - j, w), y, ch, h, r)
                                 + vpass(clamp_to(x + j, w), y, ch, h, r));
        acc = (acc + (64'd1 << 23)) >> 24;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function automatic void restart_frame();
        in_x = 0; in_y = 0; out_x = 0; out_y = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FRAME_WIDTH: begin
                width_reg = val[10:0]; restart_frame();
            end
            CFG_FRAME_HEIGHT: begin
                height_reg = val[11:0]; restart_frame();
            end
            CFG_RADIUS: begin
                radius_reg = val[2:0]; restart_frame();
            end
            CFG_TAPS_LOW: tap_words[63:0] = val;
            CFG_TAPS_HIGH: tap_words[127:64] = val;
            default: ;
        endcase
    endfunction

    // advance the frame by one beat, returns 1 when a blurred pixel comes out
    function automatic bit next_pixel(t_in_beat b, output t_out_beat o);
        int unsigned w = eff_w(), h = eff_h(), r = radius_reg;
        int unsigned nx, ny;
        bit last;
        o = '0;
        if (in_x >= w || in_y > h || out_x >= w || out_y >= h) restart_frame();
        if (b.action == ACT_PIXEL && in_y < h) begin
            line_mem[(in_y % ROW_SLOTS) * LINE_COLS + in_x] = {b.blue_in, b.green_in, b.red_in};
            if (++in_x >= w) begin
                in_x = 0; in_y++;
            end
        end
        nx = (out_x + r > w - 1) ? w - 1 : out_x + r;
        ny = (out_y + r > h - 1) ? h - 1 : out_y + r;
        if (in_y * w + in_x <= ny * w + nx) return 0;
        o.red_out   = blur_chan(out_x, out_y, 0, w, h, r);
        o.green_out = blur_chan(out_x, out_y, 1, w, h, r);
        o.blue_out  = blur_chan(out_x, out_y, 2, w, h, r);
        last = (out_x == w - 1 && out_y == h - 1);
        o.frame_end = last;
        if (last) restart_frame();
        else if (++out_x >= w) begin
            out_x = 0; out_y++;
        end
        return 1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // ---------------- monitors: predictor and checker ----------------
    always @(posedge i_clk) begin
        t_out_beat p, e;
        bit got;
        if (i_rst_n) begin
            if (i_cfg_we) apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                beats_in++;
                got = next_pixel(i_in_data, p);
                // typed rows override the predictor but it still keeps the frame state
                if (cur_typed) begin
                    if (cur_has) pixel_q = {pixel_q, cur_want};
                end else if (got) begin
                    pixel_q = {pixel_q, p};
                end
            end
            if (o_out_valid && !i_out_stall) begin
                beats_out++;
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected output beat", 1, 0);
                end else begin
                    e = pixel_q.pop_front();
                    if (o_out_data.red_out !== e.red_out)
                        report_mismatch("red_out", o_out_data.red_out, e.red_out);
                    if (o_out_data.green_out !== e.green_out)
                        report_mismatch("green_out", o_out_data.green_out, e.green_out);
                    if (o_out_data.blue_out !== e.blue_out)
                        report_mismatch("blue_out", o_out_data.blue_out, e.blue_out);
                    if (o_out_data.frame_end !== e.frame_end)
                        report_mismatch("frame_end", o_out_data.frame_end, e.frame_end);
                end
            end
        end
    end

    // watchdog: cycles in which neither side moves a beat and no register is written
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len(bit calm);
        int p = $urandom_range(0, 99);
        if (calm || p < 70) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // receiver: random stall runs, calm stretches, and one long hold-off on request
    initial begin
        int rx_left = 0;
        int rx_phase = 0;
        forever begin
            @(posedge i_clk);
            if (++rx_phase == 250) begin
                rx_phase = 0;
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge i_clk);
            end else if (rx_left > 0) begin
                rx_left--;
                i_out_stall <= 1'b1;
            end else begin
                rx_left = gap_len(rx_calm);
                if (rx_left > 0) begin
                    rx_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // ---------------- sender tasks ----------------
    task automatic offer(t_in_beat b, bit typed = 0, bit has = 0, t_out_beat want = '0);
        int g = gap_len(tx_calm);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        cur_typed  <= typed;
        cur_has    <= has;
        cur_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        cur_typed  <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every pending pixel, then let the compute pipe empty
    task automatic settle();
        go_quiet();
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // drives one register write for one edge, the caller drops the enable
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h, int r, logic [127:0] taps);
        write_reg(CFG_FRAME_WIDTH, 64'(w));
        write_reg(CFG_FRAME_HEIGHT, 64'(h));
        write_reg(CFG_RADIUS, 64'(r));
        write_reg(CFG_TAPS_LOW, taps[63:0]);
        write_reg(CFG_TAPS_HIGH, taps[127:64]);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic t_in_beat rand_px();
        t_in_beat b;
        b.action   = ACT_PIXEL;
        b.red_in   = 8'($urandom);
        b.green_in = 8'($urandom);
        b.blue_in  = 8'($urandom);
        return b;
    endfunction

    // tap sets: roughly normalized, fully random, or saturating
    function automatic logic [127:0] pick_taps(int r);
        logic [127:0] t;
        int k = $urandom_range(0, 9);
        for (int j = 0; j < 8; j++) begin
            if (k < 5) t[j*16 +: 16] = (j <= r) ? 16'($urandom_range(0, 65536 / (2*r + 1)))
                                                : 16'($urandom);
            else if (k < 8) t[j*16 +: 16] = 16'($urandom);
            else t[j*16 +: 16] = 16'hFFFF;
        end
        return t;
    endfunction

    t_dir_row dir_tab [19];

    function automatic t_dir_row row(bit act, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     bit typed = 0, bit has = 0, bit fe = 0);
        t_dir_row d;
        d.beat  = '{action: act, red_in: r, green_in: g, blue_in: b};
        d.typed = typed;
        d.has   = has;
        d.want  = '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0, frame_end: fe};
        return d;
    endfunction

    task automatic run_rows(int lo, int hi);
        for (int i = lo; i <= hi; i++)
            offer(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].has, dir_tab[i].want);
    endtask

    // ---------------- main sequence ----------------
    initial begin
        int w, h, r, frames, lag, k;
        bit partial;

        width_reg = 640; height_reg = 480; radius_reg = 3; tap_words = '0;
        restart_frame();
        for (int i = 0; i < ROW_SLOTS * LINE_COLS; i++) line_mem[i] = '0;
        err_cnt = 0; beats_in = 0; beats_out = 0; n_settings = 0;
        hold_req = 0; tx_calm = 0; rx_calm = 0; idle_cyc = 0;
        cur_typed = 0; cur_has = 0; cur_want = '0;

        // default 640x480 geometry: a first pixel makes nothing
        dir_tab[0] = row(0, 8'h12, 8'h34, 8'h56, 1, 0);
        // 1x1 frame, radius 0, zero taps: every pixel is a zero frame end
        dir_tab[1] = row(0, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1);
        dir_tab[2] = row(0, 8'h00, 8'h00, 8'h00, 1, 1, 1);
        dir_tab[3] = row(1, 8'hFF, 8'hFF, 8'hFF, 1, 0);
        dir_tab[4] = row(0, 8'h80, 8'h7F, 8'h01, 1, 1, 1);
        // 3x3, radius 1: extremes, then a pixel arriving during flush and drain ticks
        for (int i = 0; i < 9; i++)
            dir_tab[5 + i] = (i % 2) ? row(0, 8'h00, 8'hFF, 8'h00) : row(0, 8'hFF, 8'h00, 8'hFF);
        dir_tab[14] = row(0, 8'hAA, 8'h55, 8'hAA);
        for (int i = 15; i < 19; i++) dir_tab[i] = row(1, 8'h00, 8'h00, 8'h00);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_rows(0, 0);
        settle();
        set_frame(1, 1, 0, '0);
        run_rows(1, 4);
        settle();
        set_frame(3, 3, 1, {96'd0, 16'h4000, 16'h8000});
        run_rows(5, 18);
        settle();

        // random frames, the first few settings are the extremes
        k = 0;
        while (beats_in < ITEM_GOAL + 19) begin
            partial = 0;
            frames = $urandom_range(1, 2);
            case (k)
                0: begin w = 2047; h = 1; r = 1; frames = 1; partial = 1; end  // width clamps
                1: begin w = 0; h = 0; r = 7; end                // zero dimensions act as one
                2: begin w = 1; h = 4095; r = 2; partial = 1; end
                default: begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 10);
                    r = $urandom_range(0, 7);
                end
            endcase
            set_frame(w, h, r, pick_taps(r));
            w = eff_w(); h = eff_h();
            for (int f = 0; f < frames; f++) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                if (k == 4 && f == 0) hold_req = 1;  // block fills up while the receiver sits
                if (partial) begin
                    repeat (40) offer(rand_px());
                end else begin
                    for (int p = 0; p < w * h; p++) begin
                        if ($urandom_range(0, 9) == 0) offer('{action: 1'b1, default: '0});
                        if (k == 5 && f == 0 && p == (w * h) / 2) begin
                            go_quiet();
                            while (pixel_q.size() != 0) @(posedge i_clk);
                        end
                        offer(rand_px());
                    end
                    lag = ((r < h - 1) ? r : h - 1) * w + ((r < w - 1) ? r : w - 1);
                    for (int d = 0; d < lag + 2; d++) begin
                        // pixels while the frame is flushing are dropped but still flush
                        if (d < lag && $urandom_range(0, 4) == 0) offer(rand_px());
                        else offer('{action: 1'b1, red_in: 8'($urandom),
                                     green_in: 8'($urandom), blue_in: 8'($urandom)});
                    end
                end
            end
            settle();
            k++;
        end

        settle();
        $display("covered %0d input beats and %0d blurred pixels over %0d frame settings,",
                 beats_in, beats_out, n_settings);
        $display("including clamped and zero dimensions, radius 0 to 7 and a long output hold");
        if (err_cnt == 0 && pixel_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d pixels never seen", err_cnt, pixel_q.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
